/* rtl/rbpe_pkg.sv */
`timescale 1ns / 1ps
package rbpe_pkg;

  localparam int DEF_RING_DEPTH = 8192;
  localparam int DEF_FIR_TAPS   = 7;
  localparam int QUEUE_DEPTH    = 4;

  localparam int SAMPLE_W   = 32;
  localparam int PHASE_FRAC = 12;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 15;
  localparam int ECHO_SHIFT = 14;
  localparam int MIX_W      = SAMPLE_W + GAIN_W;
  localparam int COEF_W     = 22;
  localparam int COEF_FRAC  = 20;
  localparam int COEF_COUNT = 7;
  localparam int TREE_N     = 8;
  localparam int ACC_W      = 64;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [PHASE_FRAC:0] STEP_UNITY = 13'd4096;
  localparam logic [PHASE_FRAC:0] STEP_DOWN  = 13'd5120;
  localparam logic [PHASE_FRAC:0] STEP_UP    = 13'd3482;

  localparam logic signed [GAIN_W-1:0] GAIN_NEAR = 16'sd29491;
  localparam logic signed [GAIN_W-1:0] GAIN_FAR  = 16'sd9830;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -64'sh0000_0000_8000_0000;

  typedef enum logic {
    MODE_PITCH = 1'b0,
    MODE_ECHO  = 1'b1
  } effect_mode_t;

  typedef enum logic [1:0] {
    PITCH_UNITY = 2'd0,
    PITCH_LOWER = 2'd1,
    PITCH_RAISE = 2'd2
  } pitch_sel_t;

  typedef enum logic {
    REG_EFFECT_MODE  = 1'b0,
    REG_PITCH_SELECT = 1'b1
  } reg_idx_t;

  // per-request control carried from the front end to the memory stage
  typedef struct packed {
    effect_mode_t mode;
    logic         near_ok;
    logic         far_ok;
  } rbpe_ctl_t;

  function automatic logic signed [COEF_W-1:0] fir_coef(input int idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      0, 6:    c = 22'sd315;
      1, 5:    c = -22'sd105;
      2, 4:    c = 22'sd105;
      3:       c = 22'sd1048471;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic [SAMPLE_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/rbpe_front.sv */
`timescale 1ns / 1ps
module rbpe_front import rbpe_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [SAMPLE_W-1:0]         sample_in,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  effect_mode_t                       effect_mode,
  input  logic [1:0]                         pitch_select,
  input  logic                               q_full,
  output logic                               q_push,
  output logic [SAMPLE_W-1:0]                q_sample,
  output logic [$clog2(RING_DEPTH)-1:0]      q_waddr,
  output logic [$clog2(RING_DEPTH)-1:0]      q_raddr_near,
  output logic [$clog2(RING_DEPTH)-1:0]      q_raddr_far,
  output rbpe_ctl_t                          q_ctl
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int PW = AW + PHASE_FRAC;

  logic [AW-1:0]         wp;
  logic                  wrapped;
  logic [PW-1:0]         phase;
  logic [AW-1:0]         echo_ptr;
  logic [PHASE_FRAC:0]   step;
  logic                  accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign q_sample = sample_in;
  assign q_waddr  = wp;

  always_comb begin
    case (pitch_select)
      PITCH_LOWER: step = STEP_DOWN;
      PITCH_RAISE: step = STEP_UP;
      default:     step = STEP_UNITY;
    endcase
    if (effect_mode == MODE_ECHO) begin
      q_raddr_near = echo_ptr;
    end else begin
      q_raddr_near = phase[PW-1:PHASE_FRAC];
    end
    q_raddr_far   = echo_ptr + AW'(RING_DEPTH / 2);
    // entries are written in order from zero, so anything at or below the
    // write address (this request's write included) holds a real sample
    q_ctl.mode    = effect_mode;
    q_ctl.near_ok = wrapped || (q_raddr_near <= wp);
    q_ctl.far_ok  = wrapped || (q_raddr_far <= wp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      wrapped  <= 1'b0;
      phase    <= '0;
      echo_ptr <= '0;
    end else if (accept) begin
      wp <= wp + 1'b1;
      if (wp == {AW{1'b1}}) begin
        wrapped <= 1'b1;
      end
      if (effect_mode == MODE_ECHO) begin
        echo_ptr <= echo_ptr + 1'b1;
      end else begin
        phase <= phase + PW'(step);
      end
    end
  end

endmodule

/* rtl/rbpe_queue.sv */
`timescale 1ns / 1ps
module rbpe_queue import rbpe_pkg::*; #(
  parameter int WIDTH = SAMPLE_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/rbpe_back.sv */
`timescale 1ns / 1ps
module rbpe_back import rbpe_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  logic [SAMPLE_W-1:0]            q_sample,
  input  logic [$clog2(RING_DEPTH)-1:0]  q_waddr,
  input  logic [$clog2(RING_DEPTH)-1:0]  q_raddr_near,
  input  logic [$clog2(RING_DEPTH)-1:0]  q_raddr_far,
  input  rbpe_ctl_t                      q_ctl,
  output logic                           v_valid,
  output logic signed [SAMPLE_W-1:0]     v_data
);

  localparam int QW = MIX_W - GAIN_FRAC;

  logic [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic                issue;

  logic [SAMPLE_W-1:0] rd_near;
  logic [SAMPLE_W-1:0] rd_far;
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  rbpe_ctl_t           s1_ctl;
  logic                s1_fwd_near;
  logic                s1_fwd_far;

  logic signed [SAMPLE_W-1:0] near;
  logic signed [SAMPLE_W-1:0] far;

  logic                       s2_valid;
  effect_mode_t               s2_mode;
  logic signed [SAMPLE_W-1:0] s2_pitch;
  logic signed [MIX_W-1:0]    s2_prod_near;
  logic signed [MIX_W-1:0]    s2_prod_far;

  logic                       s3_valid;
  effect_mode_t               s3_mode;
  logic signed [SAMPLE_W-1:0] s3_pitch;
  logic signed [MIX_W-1:0]    s3_sum;

  logic signed [MIX_W-1:0]    bias;
  logic signed [MIX_W-1:0]    biased;
  logic signed [QW-1:0]       quot;
  logic [SAMPLE_W-1:0]        mix_sat;
  logic [SAMPLE_W-1:0]        echo_val;

  assign issue = adv && !q_empty;
  assign q_pop = issue;

  // the read sees the old word at the write address; the write of this
  // request is forwarded from the s1 sample register
  always_ff @(posedge clk) begin
    if (issue) begin
      ring[q_waddr] <= q_sample;
    end
    if (adv) begin
      rd_near <= ring[q_raddr_near];
      rd_far  <= ring[q_raddr_far];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample   <= q_sample;
      s1_ctl      <= q_ctl;
      s1_fwd_near <= (q_raddr_near == q_waddr);
      s1_fwd_far  <= (q_raddr_far == q_waddr);
    end
  end

  always_comb begin
    if (!s1_ctl.near_ok) begin
      near = '0;
    end else if (s1_fwd_near) begin
      near = s1_sample;
    end else begin
      near = rd_near;
    end
    if (!s1_ctl.far_ok) begin
      far = '0;
    end else if (s1_fwd_far) begin
      far = s1_sample;
    end else begin
      far = rd_far;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mode      <= s1_ctl.mode;
      s2_pitch     <= near;
      s2_prod_near <= MIX_W'(near) * MIX_W'(GAIN_NEAR);
      s2_prod_far  <= MIX_W'(far) * MIX_W'(GAIN_FAR);
      s3_mode      <= s2_mode;
      s3_pitch     <= s2_pitch;
      s3_sum       <= s2_prod_near + s2_prod_far;
    end
  end

  // divide by the gain scale toward zero, saturate, then floor-shift
  always_comb begin
    bias     = s3_sum[MIX_W-1] ? MIX_W'(2 ** GAIN_FRAC - 1) : '0;
    biased   = s3_sum + bias;
    quot     = biased[MIX_W-1:GAIN_FRAC];
    mix_sat  = sat_sample(ACC_W'(quot));
    echo_val = {{ECHO_SHIFT{mix_sat[SAMPLE_W-1]}}, mix_sat[SAMPLE_W-1:ECHO_SHIFT]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_data <= (s3_mode == MODE_ECHO) ? echo_val : s3_pitch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      v_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      v_valid  <= s3_valid;
    end
  end

endmodule

/* rtl/rbpe_fir.sv */
`timescale 1ns / 1ps
module rbpe_fir import rbpe_pkg::*; #(
  parameter int FIR_TAPS = DEF_FIR_TAPS
) (
  input  logic                       clk,
  input  logic                       rst,
  output logic                       adv,
  input  logic                       v_valid,
  input  logic signed [SAMPLE_W-1:0] v_data,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       out_valid,
  input  logic                       out_stall
);

  // taps past the coefficient table are zero and need no storage
  localparam int NPROD  = (FIR_TAPS < COEF_COUNT) ? FIR_TAPS : COEF_COUNT;
  localparam int DL     = NPROD - 1;
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int QW     = ACC_W - COEF_FRAC;

  logic signed [SAMPLE_W-1:0] dl   [DL];
  logic signed [SAMPLE_W-1:0] tap  [NPROD];
  logic signed [PROD_W-1:0]   prod [NPROD];
  logic signed [ACC_W-1:0]    leaf [TREE_N];
  logic signed [ACC_W-1:0]    l1   [TREE_N / 2];
  logic signed [ACC_W-1:0]    l2   [TREE_N / 4];
  logic signed [ACC_W-1:0]    total;
  logic                       f1_valid;
  logic                       f2_valid;
  logic                       f3_valid;
  logic                       f4_valid;

  logic signed [ACC_W-1:0]    bias;
  logic signed [ACC_W-1:0]    biased;
  logic signed [QW-1:0]       quot;

  assign adv = !out_valid || !out_stall;

  always_comb begin
    tap[0] = v_data;
    for (int i = 1; i < NPROD; i++) begin
      tap[i] = dl[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NPROD; i++) begin
        prod[i] <= PROD_W'(tap[i]) * PROD_W'(fir_coef(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DL; i++) begin
        dl[i] <= '0;
      end
    end else if (adv && v_valid) begin
      dl[0] <= v_data;
      for (int i = 1; i < DL; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  for (genvar g = 0; g < TREE_N; g++) begin : g_leaf
    if (g < NPROD) begin : g_used
      assign leaf[g] = ACC_W'(prod[g]);
    end else begin : g_pad
      assign leaf[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < TREE_N / 2; j++) begin
        l1[j] <= leaf[2*j] + leaf[2*j+1];
      end
      for (int k = 0; k < TREE_N / 4; k++) begin
        l2[k] <= l1[2*k] + l1[2*k+1];
      end
      total <= l2[0] + l2[1];
    end
  end

  always_comb begin
    bias   = total[ACC_W-1] ? ACC_W'(2 ** COEF_FRAC - 1) : '0;
    biased = total + bias;
    quot   = biased[ACC_W-1:COEF_FRAC];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_out <= sat_sample(ACC_W'(quot));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid  <= 1'b0;
      f2_valid  <= 1'b0;
      f3_valid  <= 1'b0;
      f4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      f1_valid  <= v_valid;
      f2_valid  <= f1_valid;
      f3_valid  <= f2_valid;
      f4_valid  <= f3_valid;
      out_valid <= f4_valid;
    end
  end

endmodule

/* rtl/ring_buffer_pitch_echo_fir_top.sv */
`timescale 1ns / 1ps
// A request passes the queue, the back-end registers and the FIR registers to sample_out.
// Throughput: one request per cycle unless out_stall holds it; the ring has one write and two
// read ports, so the memory stage takes both echo taps and the write of a request at once.
// Reset (rst, synchronous, active high) clears pointers, phase, FIR history, the queue,
// the pipeline and the registers; the ring itself is not swept, unwritten entries read as 0.
module ring_buffer_pitch_echo_fir_top import rbpe_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int FIR_TAPS   = DEF_FIR_TAPS
) (
  input  logic                       clk,
  input  logic                       rst,
  // sample requests in
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       in_valid,
  output logic                       in_stall,
  // filtered samples out
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       out_valid,
  input  logic                       out_stall,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $bits(rbpe_ctl_t);
  localparam int QW = SAMPLE_W + 3 * AW + CW;

  effect_mode_t effect_mode;
  logic [1:0]   pitch_select;
  reg_idx_t     reg_idx;

  // front end to queue
  logic                q_push;
  logic                q_full;
  logic [SAMPLE_W-1:0] f_sample;
  logic [AW-1:0]       f_waddr;
  logic [AW-1:0]       f_raddr_near;
  logic [AW-1:0]       f_raddr_far;
  rbpe_ctl_t           f_ctl;
  logic [QW-1:0]       q_in;

  // queue to back end
  logic                q_pop;
  logic                q_empty;
  logic [QW-1:0]       q_out;
  logic [SAMPLE_W-1:0] b_sample;
  logic [AW-1:0]       b_waddr;
  logic [AW-1:0]       b_raddr_near;
  logic [AW-1:0]       b_raddr_far;
  rbpe_ctl_t           b_ctl;

  // back end to FIR
  logic                       adv;
  logic                       v_valid;
  logic signed [SAMPLE_W-1:0] v_data;

  // Register port: word address selects the register, low address bits are
  // ignored. Writes are only expected while the block is idle.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode  <= MODE_PITCH;
      pitch_select <= PITCH_UNITY;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_EFFECT_MODE:  effect_mode  <= effect_mode_t'(pwdata[0]);
        REG_PITCH_SELECT: pitch_select <= pwdata[1:0];
        default:          effect_mode  <= effect_mode;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EFFECT_MODE:  prdata = {{(DATA_W-1){1'b0}}, effect_mode};
      REG_PITCH_SELECT: prdata = {{(DATA_W-2){1'b0}}, pitch_select};
      default:          prdata = '0;
    endcase
  end

  // Front end: take each request, work out its write address and read
  // taps from the phase or echo pointer, and note which taps are live.
  rbpe_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_in    (sample_in),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .effect_mode  (effect_mode),
    .pitch_select (pitch_select),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_sample     (f_sample),
    .q_waddr      (f_waddr),
    .q_raddr_near (f_raddr_near),
    .q_raddr_far  (f_raddr_far),
    .q_ctl        (f_ctl)
  );

  // Queue: decouple the front end from a stalled back end; the front end
  // keeps taking requests until it fills.
  assign q_in = {f_sample, f_waddr, f_raddr_near, f_raddr_far, f_ctl};

  rbpe_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign b_sample     = q_out[QW-1 -: SAMPLE_W];
  assign b_waddr      = q_out[CW + 3*AW - 1 -: AW];
  assign b_raddr_near = q_out[CW + 2*AW - 1 -: AW];
  assign b_raddr_far  = q_out[CW + AW - 1 -: AW];
  assign b_ctl        = rbpe_ctl_t'(q_out[CW-1:0]);

  // Back end: ring write and reads, echo mix or pitch pick-up.
  rbpe_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_sample     (b_sample),
    .q_waddr      (b_waddr),
    .q_raddr_near (b_raddr_near),
    .q_raddr_far  (b_raddr_far),
    .q_ctl        (b_ctl),
    .v_valid      (v_valid),
    .v_data       (v_data)
  );

  // FIR and output register; the whole back pipeline holds while a
  // finished result waits under stall.
  rbpe_fir #(
    .FIR_TAPS (FIR_TAPS)
  ) u_fir (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .v_valid    (v_valid),
    .v_data     (v_data),
    .sample_out (sample_out),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

endmodule
